@@ rtl/conv2d_pkg.sv @@
// ----------------------------------------------------------------------------
// conv2d_pkg: shared types and constants
// widths, register indexes and sequencer states of the 3x3 filter unit
// ----------------------------------------------------------------------------
package conv2d_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int KERNEL_SIDE = 3;
   localparam int COORD_W     = $clog2(MAX_SIDE);
   localparam int SIDE_W      = COORD_W + 1;
   localparam int ADDR_W      = 2 * COORD_W;
   localparam int PIX_W       = 8;
   localparam int COEF_W      = 16;
   localparam int COEF_ROW_W  = KERNEL_SIDE * COEF_W;
   localparam int PROD_W      = COEF_W + PIX_W + 1;
   localparam int ACC_W       = 28;
   localparam int OUT_W       = 20;
   localparam int FRAC_W      = 8;
   localparam int TAP_W       = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MIDDLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOTTOM  = 3'd4;

   localparam logic [SIDE_W-1:0]     RST_IMAGE_SIDE  = SIDE_W'(MAX_SIDE);
   localparam logic [COEF_ROW_W-1:0] RST_COEF_EDGE   = '0;
   localparam logic [COEF_ROW_W-1:0] RST_COEF_MIDDLE = 48'h0000_0100_0000;

   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } seq_state_type;

endpackage

@@ rtl/conv2d_replicate_border_unit.sv @@
// ----------------------------------------------------------------------------
// conv2d_replicate_border_unit: 3x3 convolution over a stored frame
// keeps a 64x64 frame of 8-bit pixels and filters it with replicated borders
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser selects the request kind (0 store pixel, 1 filter),
//     tdata carries row, col and pixel value
//   rsp channel: one filtered value per filter request, none for a store
//   csr port: image size and the three kernel rows (three signed Q8.8 each)
// timing
//   a store request keeps the sequencer idle, the next request is accepted right after
//   a filter request issues its nine taps, drains the pipeline and then waits for the
//   output register to load its result; the taps are read one per cycle from the
//   single frame memory read port and go through one shared multiplier and accumulator,
//   which sets the rate; the block is not ready while a filter request is in work, so
//   the next request is accepted only once the result is in the output register
// reset and stalls
//   reset restores the image size and kernel registers and idles the sequencer;
//   the frame memory is not cleared, pixels must be stored before use
//   a result waits in the output register while the receiver stalls; the next
//   request is still accepted, and a second result holds in the sequencer
//   until the output register frees up
// ----------------------------------------------------------------------------
module conv2d_replicate_border_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,  // row[5:0], col[11:6], pixel_value[19:12]
   input  logic                                  req_tuser,  // req_type
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [23:0]                           rsp_tdata,  // filtered_value[19:0]
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [conv2d_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [conv2d_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [conv2d_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int CW = conv2d_pkg::COORD_W;
   localparam int SW = conv2d_pkg::SIDE_W;

   // clamp a size register into 1..MAX_SIDE
   function automatic logic [SW-1:0] side_in_use(input logic [SW-1:0] v);
      logic [SW-1:0] r;
      begin
         if (v == '0) begin
            r = SW'(1);
         end else if (v > SW'(conv2d_pkg::MAX_SIDE)) begin
            r = SW'(conv2d_pkg::MAX_SIDE);
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

   // neighbour coordinate base + 1 - tap, clamped into 0..size-1
   function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] base,
                                                 input logic [conv2d_pkg::TAP_W-1:0] tap,
                                                 input logic [SW-1:0] size);
      logic signed [SW:0] v;
      logic [CW-1:0]      r;
      begin
         v = $signed({2'b00, base}) + $signed((SW+1)'(1)) - $signed({{(SW-1){1'b0}}, tap});
         if (v[SW]) begin
            r = '0;
         end else if (v[SW-1:0] >= size) begin
            r = CW'(size - SW'(1));
         end else begin
            r = v[CW-1:0];
         end
         return r;
      end
   endfunction

   // ---------------------------------------------------------------- registers
   logic [SW-1:0]                         image_width_ff;
   logic [SW-1:0]                         image_height_ff;
   logic [conv2d_pkg::COEF_ROW_W-1:0]     coef_top_ff;
   logic [conv2d_pkg::COEF_ROW_W-1:0]     coef_middle_ff;
   logic [conv2d_pkg::COEF_ROW_W-1:0]     coef_bottom_ff;

   logic                                  csr_wr;
   logic [conv2d_pkg::CSR_IDX_W-1:0]      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[conv2d_pkg::CSR_ADDR_W-1:conv2d_pkg::CSR_ADDR_W-conv2d_pkg::CSR_IDX_W];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= conv2d_pkg::RST_IMAGE_SIDE;
         image_height_ff <= conv2d_pkg::RST_IMAGE_SIDE;
         coef_top_ff     <= conv2d_pkg::RST_COEF_EDGE;
         coef_middle_ff  <= conv2d_pkg::RST_COEF_MIDDLE;
         coef_bottom_ff  <= conv2d_pkg::RST_COEF_EDGE;
      end else if (csr_wr) begin
         case (csr_idx)
            conv2d_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[SW-1:0];
            conv2d_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[SW-1:0];
            conv2d_pkg::CSR_COEF_TOP:     coef_top_ff     <= csr_pwdata[conv2d_pkg::COEF_ROW_W-1:0];
            conv2d_pkg::CSR_COEF_MIDDLE:  coef_middle_ff  <= csr_pwdata[conv2d_pkg::COEF_ROW_W-1:0];
            conv2d_pkg::CSR_COEF_BOTTOM:  coef_bottom_ff  <= csr_pwdata[conv2d_pkg::COEF_ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         conv2d_pkg::CSR_IMAGE_WIDTH:  csr_prdata = conv2d_pkg::CSR_DATA_W'(image_width_ff);
         conv2d_pkg::CSR_IMAGE_HEIGHT: csr_prdata = conv2d_pkg::CSR_DATA_W'(image_height_ff);
         conv2d_pkg::CSR_COEF_TOP:     csr_prdata = conv2d_pkg::CSR_DATA_W'(coef_top_ff);
         conv2d_pkg::CSR_COEF_MIDDLE:  csr_prdata = conv2d_pkg::CSR_DATA_W'(coef_middle_ff);
         conv2d_pkg::CSR_COEF_BOTTOM:  csr_prdata = conv2d_pkg::CSR_DATA_W'(coef_bottom_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- request
   logic [CW-1:0]               req_row;
   logic [CW-1:0]               req_col;
   logic [conv2d_pkg::PIX_W-1:0] req_pixel;
   logic                        req_acc;
   logic                        req_store;
   logic                        req_filter;

   assign req_row    = req_tdata[CW-1:0];
   assign req_col    = req_tdata[2*CW-1:CW];
   assign req_pixel  = req_tdata[2*CW+conv2d_pkg::PIX_W-1:2*CW];
   assign req_acc    = req_tvalid & req_tready;
   assign req_store  = req_acc & (req_tuser == conv2d_pkg::REQ_WRITE);
   assign req_filter = req_acc & (req_tuser == conv2d_pkg::REQ_COMPUTE);

   // ---------------------------------------------------------------- sequencer
   conv2d_pkg::seq_state_type state_ff, state_in;

   logic [conv2d_pkg::TAP_W-1:0] kr_ff, kr_in;   // kernel row of the tap being issued
   logic [conv2d_pkg::TAP_W-1:0] kc_ff, kc_in;   // kernel column
   logic [CW-1:0]                row_ff;
   logic [CW-1:0]                col_ff;
   logic                         issue;
   logic                         last_tap;
   logic                         out_free;
   logic                         out_load;

   assign last_tap = (kr_ff == conv2d_pkg::TAP_W'(conv2d_pkg::KERNEL_SIDE - 1)) &&
                     (kc_ff == conv2d_pkg::TAP_W'(conv2d_pkg::KERNEL_SIDE - 1));

   // pipeline after issue: memory read, multiply, accumulate
   logic                                 s1_vld_ff;
   logic                                 s1_last_ff;
   logic signed [conv2d_pkg::COEF_W-1:0] s1_coef_ff;
   logic [conv2d_pkg::PIX_W-1:0]         rd_data_ff;
   logic                                 s2_vld_ff;
   logic                                 s2_last_ff;
   logic signed [conv2d_pkg::PROD_W-1:0] prod_ff;
   logic signed [conv2d_pkg::ACC_W-1:0]  acc_ff;

   logic                         rsp_valid_ff;
   logic [conv2d_pkg::OUT_W-1:0] rsp_data_ff;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= conv2d_pkg::ST_IDLE;
         kr_ff    <= '0;
         kc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         kr_ff    <= kr_in;
         kc_ff    <= kc_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      kr_in      = kr_ff;
      kc_in      = kc_ff;
      req_tready = 1'b0;
      issue      = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         conv2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_filter) begin
               state_in = conv2d_pkg::ST_ISSUE;
               kr_in    = '0;
               kc_in    = '0;
            end
         end
         conv2d_pkg::ST_ISSUE: begin
            issue = 1'b1;
            if (kc_ff == conv2d_pkg::TAP_W'(conv2d_pkg::KERNEL_SIDE - 1)) begin
               kc_in = '0;
               kr_in = kr_ff + conv2d_pkg::TAP_W'(1);
            end else begin
               kc_in = kc_ff + conv2d_pkg::TAP_W'(1);
            end
            if (last_tap) begin
               state_in = conv2d_pkg::ST_DRAIN;
            end
         end
         conv2d_pkg::ST_DRAIN: begin
            // last product enters the accumulator this cycle
            if (s2_vld_ff && s2_last_ff) begin
               state_in = conv2d_pkg::ST_DONE;
            end
         end
         conv2d_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = conv2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = conv2d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_filter) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
   end

   // ---------------------------------------------------------------- tap address
   logic [SW-1:0]                width_eff;
   logic [SW-1:0]                height_eff;
   logic [CW-1:0]                tap_row;
   logic [CW-1:0]                tap_col;
   logic [conv2d_pkg::ADDR_W-1:0] rd_addr;
   logic [conv2d_pkg::COEF_ROW_W-1:0] coef_row;
   logic [conv2d_pkg::COEF_W-1:0] tap_coef;

   assign width_eff  = side_in_use(image_width_ff);
   assign height_eff = side_in_use(image_height_ff);
   // true convolution: kernel row kr looks at row - (kr - 1)
   assign tap_row    = clamp_coord(row_ff, kr_ff, height_eff);
   assign tap_col    = clamp_coord(col_ff, kc_ff, width_eff);
   assign rd_addr    = {tap_row, tap_col};

   always_comb begin
      case (kr_ff)
         2'd0:    coef_row = coef_top_ff;
         2'd1:    coef_row = coef_middle_ff;
         default: coef_row = coef_bottom_ff;
      endcase
      case (kc_ff)
         2'd0:    tap_coef = coef_row[conv2d_pkg::COEF_W-1:0];
         2'd1:    tap_coef = coef_row[2*conv2d_pkg::COEF_W-1:conv2d_pkg::COEF_W];
         default: tap_coef = coef_row[3*conv2d_pkg::COEF_W-1:2*conv2d_pkg::COEF_W];
      endcase
   end

   // ---------------------------------------------------------------- frame memory
   // one write port for stores, one registered read port for the taps
   logic [conv2d_pkg::PIX_W-1:0] frame_mem [conv2d_pkg::MAX_SIDE * conv2d_pkg::MAX_SIDE];

   always_ff @(posedge clock) begin
      if (req_store) begin
         frame_mem[{req_row, req_col}] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= frame_mem[rd_addr];
   end

   // ---------------------------------------------------------------- shared mac
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= last_tap;
      s1_coef_ff <= $signed(tap_coef);
      s2_last_ff <= s1_last_ff;
      prod_ff    <= s1_coef_ff * $signed({1'b0, rd_data_ff});
      if (req_filter) begin
         acc_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff <= acc_ff + conv2d_pkg::ACC_W'(prod_ff);
      end
   end

   // ---------------------------------------------------------------- result
   // drop the Q8.8 fraction, rounding toward zero: bias negatives by 255
   logic signed [conv2d_pkg::ACC_W-1:0] acc_biased;

   assign acc_biased = acc_ff + $signed({{(conv2d_pkg::ACC_W-conv2d_pkg::FRAC_W){1'b0}},
                                         {conv2d_pkg::FRAC_W{acc_ff[conv2d_pkg::ACC_W-1]}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= acc_biased[conv2d_pkg::FRAC_W+conv2d_pkg::OUT_W-1:conv2d_pkg::FRAC_W];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

@@ tb/conv2d_replicate_border_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_replicate_border_unit_tb: self-checking bench for the 3x3 filter unit
// stores pixels, filters at random positions and compares every filtered value
// against a behavioral copy of the unit, over several image sizes, kernels and
// handshake stall patterns
// ----------------------------------------------------------------------------
module conv2d_replicate_border_unit_tb;

   // register index with no register behind it, writes must be dropped
   localparam logic [conv2d_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd5;

   localparam int FRAME_SIZE  = conv2d_pkg::MAX_SIDE * conv2d_pkg::MAX_SIDE;
   localparam int TAIL_CYCLES = 30;    // idle margin beyond the filter latency
   localparam int LONG_HOLD   = 400;   // receiver back-pressure stretch
   localparam int SHOW_MAX    = 10;

   localparam logic [conv2d_pkg::COEF_ROW_W-1:0] COEF_ALL_MAX = {3{16'h7FFF}};
   localparam logic [conv2d_pkg::COEF_ROW_W-1:0] COEF_ALL_MIN = {3{16'h8000}};

   // one queued request; a pause entry holds the sender until all results came
   typedef struct packed {
      logic       pause;
      logic       kind;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] pixel;
   } pixel_req_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [23:0]                         req_tdata = '0;   // row[5:0], col[11:6], pixel_value[19:12]
   logic                                req_tuser = 1'b0; // req_type
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [23:0]                         rsp_tdata;        // filtered_value[19:0]
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [conv2d_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [conv2d_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [conv2d_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                                csr_pready;

   conv2d_replicate_border_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // shadow of the unit: register copy and frame copy, updated on accept
   // ------------------------------------------------------------------------
   logic [6:0]                          cfg_width  = 7'd64;
   logic [6:0]                          cfg_height = 7'd64;
   logic [conv2d_pkg::COEF_ROW_W-1:0]   cfg_coef [conv2d_pkg::KERNEL_SIDE] =
      '{conv2d_pkg::RST_COEF_EDGE, conv2d_pkg::RST_COEF_MIDDLE, conv2d_pkg::RST_COEF_EDGE};
   logic [conv2d_pkg::PIX_W-1:0]        frame_px [FRAME_SIZE];

   pixel_req_type                       pending_q [$];   // requests waiting for the driver
   logic [conv2d_pkg::OUT_W-1:0]        filtered_q [$];  // filtered values still to arrive
   pixel_req_type                       req_on_bus;
   bit                                  gen_written [FRAME_SIZE];  // pixels already scheduled

   int                                  send_idle_pct = 0;
   int                                  rsp_stall_pct = 0;
   int                                  hold_requests = 0;
   int                                  fault_count   = 0;

   // size registers: zero behaves as one, anything above the store as the store
   function automatic int side_used(logic [6:0] v);
      if (v == 0) return 1;
      if (v > conv2d_pkg::MAX_SIDE) return conv2d_pkg::MAX_SIDE;
      return int'(v);
   endfunction

   function automatic int clamp_idx(int v, int size);
      if (v < 0) return 0;
      if (v >= size) return size - 1;
      return v;
   endfunction

   // true convolution: kernel tap (k+1, l+1) weights pixel (r-k, c-l),
   // neighbors clamped into the image in use, Q8.8 sum cut toward zero
   function automatic logic [conv2d_pkg::OUT_W-1:0] filter_at(int r, int c);
      int                 w, h, pix;
      logic signed [15:0] tap;
      longint             acc, res;
      w   = side_used(cfg_width);
      h   = side_used(cfg_height);
      acc = 0;
      for (int k = -1; k <= 1; k++) begin
         for (int l = -1; l <= 1; l++) begin
            tap = cfg_coef[k + 1][conv2d_pkg::COEF_W * (l + 1) +: conv2d_pkg::COEF_W];
            pix = frame_px[clamp_idx(r - k, h) * conv2d_pkg::MAX_SIDE + clamp_idx(c - l, w)];
            acc += longint'(int'(tap) * pix);
         end
      end
      if (acc < 0) res = -((-acc) >>> conv2d_pkg::FRAC_W);
      else res = acc >>> conv2d_pkg::FRAC_W;
      return conv2d_pkg::OUT_W'(res);
   endfunction

   function automatic void track_request(pixel_req_type item);
      if (item.kind == conv2d_pkg::REQ_WRITE) frame_px[{item.row, item.col}] = item.pixel;
      else filtered_q.push_back(filter_at(item.row, item.col));
   endfunction

   function automatic void report_fault(string what);
      if (fault_count < SHOW_MAX) $display("%0t: %s", $realtime, what);
      fault_count++;
   endfunction

   // ------------------------------------------------------------------------
   // request generation
   // ------------------------------------------------------------------------
   function automatic void push_store(int r, int c, int p);
      pending_q.push_back('{pause: 1'b0, kind: conv2d_pkg::REQ_WRITE, row: 6'(r), col: 6'(c),
                            pixel: 8'(p)});
      gen_written[r * conv2d_pkg::MAX_SIDE + c] = 1'b1;
   endfunction

   // stores any neighbor that was never written first, so a filter request
   // never reads an undefined frame entry
   function automatic void push_filter(int r, int c);
      int w, h, pr, pc;
      w = side_used(cfg_width);
      h = side_used(cfg_height);
      for (int k = -1; k <= 1; k++) begin
         for (int l = -1; l <= 1; l++) begin
            pr = clamp_idx(r - k, h);
            pc = clamp_idx(c - l, w);
            if (!gen_written[pr * conv2d_pkg::MAX_SIDE + pc])
               push_store(pr, pc, $urandom_range(255));
         end
      end
      // pixel field is unused by a filter request, send noise anyway
      pending_q.push_back('{pause: 1'b0, kind: conv2d_pkg::REQ_COMPUTE, row: 6'(r),
                            col: 6'(c), pixel: 8'($urandom)});
   endfunction

   // mostly inside the image, often on its edge, sometimes anywhere in the store
   function automatic int pick_coord(int side);
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) return $urandom_range(side - 1);
      if (sel < 70) return $urandom_range(1) ? side - 1 : 0;
      return $urandom_range(conv2d_pkg::MAX_SIDE - 1);
   endfunction

   function automatic void push_random_mix(int n);
      int w, h, p;
      w = side_used(cfg_width);
      h = side_used(cfg_height);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 45) begin
            if ($urandom_range(9) == 0) p = $urandom_range(1) ? 255 : 0;
            else p = $urandom_range(255);
            push_store(pick_coord(h), pick_coord(w), p);
         end else begin
            push_filter(pick_coord(h), pick_coord(w));
         end
      end
   endfunction

   function automatic void push_pause();
      pending_q.push_back('{pause: 1'b1, kind: conv2d_pkg::REQ_WRITE, row: '0, col: '0,
                            pixel: '0});
   endfunction

   // ------------------------------------------------------------------------
   // register port: setup cycle then access cycle, shadow updated with it
   // ------------------------------------------------------------------------
   task automatic write_csr(input logic [conv2d_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         conv2d_pkg::CSR_IMAGE_WIDTH:  cfg_width   = value[6:0];
         conv2d_pkg::CSR_IMAGE_HEIGHT: cfg_height  = value[6:0];
         conv2d_pkg::CSR_COEF_TOP:     cfg_coef[0] = value[conv2d_pkg::COEF_ROW_W-1:0];
         conv2d_pkg::CSR_COEF_MIDDLE:  cfg_coef[1] = value[conv2d_pkg::COEF_ROW_W-1:0];
         conv2d_pkg::CSR_COEF_BOTTOM:  cfg_coef[2] = value[conv2d_pkg::COEF_ROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame_config(input logic [63:0] w, input logic [63:0] h,
                                   input logic [63:0] top, input logic [63:0] mid,
                                   input logic [63:0] bot);
      write_csr(conv2d_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(conv2d_pkg::CSR_IMAGE_HEIGHT, h);
      write_csr(conv2d_pkg::CSR_COEF_TOP, top);
      write_csr(conv2d_pkg::CSR_COEF_MIDDLE, mid);
      write_csr(conv2d_pkg::CSR_COEF_BOTTOM, bot);
   endtask

   // idle point: every request sent, every result back, pipeline emptied
   task automatic wait_drained();
      while (pending_q.size() != 0 || filtered_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // request driver: a request is taken when tvalid and tready meet at an edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      pixel_req_type item;
      logic          send;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) track_request(req_on_bus);
         if (!req_tvalid || req_tready) begin
            // a pause entry clears only once nothing is outstanding
            if (pending_q.size() != 0 && pending_q[0].pause && filtered_q.size() == 0)
               item = pending_q.pop_front();
            send = pending_q.size() != 0 && !pending_q[0].pause &&
                   ($urandom_range(99) >= send_idle_pct);
            if (send) begin
               item       = pending_q.pop_front();
               req_on_bus = item;
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, item.pixel, item.col, item.row};
               req_tuser  <= item.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result side: random stalls, long holds on request, in-order compare
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : take_results
      logic [conv2d_pkg::OUT_W-1:0] want;
      int                           hold_left;
      int                           holds_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         holds_done = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               report_fault($sformatf("filtered value %0d with no filter request pending",
                                      $signed(rsp_tdata[conv2d_pkg::OUT_W-1:0])));
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata[conv2d_pkg::OUT_W-1:0] !== want)
                  report_fault($sformatf("filtered_value mismatch: expected %0d, got %0d",
                                         $signed(want),
                                         $signed(rsp_tdata[conv2d_pkg::OUT_W-1:0])));
            end
         end
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // phases
   // ------------------------------------------------------------------------
   initial begin : run_phases
      int w, h;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset kernel is the identity: corners, far edges and pixel extremes
      push_store(0, 0, 0);
      push_store(63, 63, 255);
      push_filter(0, 0);
      push_filter(63, 63);
      push_filter(0, 63);
      push_filter(63, 0);
      push_store(31, 31, 8'hA5);
      push_filter(31, 31);
      push_store(31, 31, 8'h5A);
      push_filter(31, 31);
      push_filter(32, 30);
      wait_drained();

      // size registers out of range: zero width, height beyond the store
      set_frame_config(64'd0, 64'd127, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
      push_filter(0, 0);
      push_filter(63, 63);
      push_random_mix(40);
      wait_drained();

      // single-pixel image, sender idling
      send_idle_pct = 53;
      set_frame_config(64'd1, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
      push_filter(40, 12);
      push_random_mix(40);
      wait_drained();

      // largest positive kernel on a saturated neighborhood, receiver stalling
      send_idle_pct = 0;
      rsp_stall_pct = 53;
      set_frame_config(64'd64, 64'd64, COEF_ALL_MAX, COEF_ALL_MAX, COEF_ALL_MAX);
      write_csr(CSR_UNMAPPED, {$urandom, $urandom});
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++) push_store(10 + dr, 10 + dc, 255);
      push_filter(10, 10);
      push_random_mix(30);
      wait_drained();

      // most negative kernel, light idling on both sides
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      set_frame_config(64'd64, 64'd64, COEF_ALL_MIN, COEF_ALL_MIN, COEF_ALL_MIN);
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++) push_store(10 + dr, 10 + dc, 255);
      push_filter(10, 10);
      push_random_mix(30);
      wait_drained();

      // back-pressure: receiver holds off while the sender keeps offering,
      // then the sender waits in mid-stream for every result to come back
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_frame_config(64'd3, 64'd5, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
      hold_requests++;
      push_random_mix(20);
      push_pause();
      push_random_mix(20);
      wait_drained();

      // random sizes and kernels, sweeping the stall patterns
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         w = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
         h = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
         // bits above the register width are junk and must not matter
         set_frame_config({57'($urandom), 7'(w)}, {57'($urandom), 7'(h)},
                          {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom});
         push_random_mix(40);
         wait_drained();
      end

      if (fault_count == 0 && filtered_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
